// ----- design/nptd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nptd_pkg
// Shared constants and types for the nested priority task dispatcher.
// ----------------------------------------------------------------------------
package nptd_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int NEST_DEPTH  = 16;
  localparam int NUM_LEVELS  = 16;
  localparam int PRIO_W      = 4;
  localparam int ID_W        = 8;
  localparam int OUT_CNT_W   = 5;

  // one sentinel node per priority level plus one node per queued task
  localparam int NODE_COUNT  = QUEUE_DEPTH + NUM_LEVELS;
  localparam int PTR_W       = $clog2(NODE_COUNT);
  localparam int NODE_W      = ID_W + PTR_W;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int SCNT_W      = $clog2(NEST_DEPTH + 1);
  localparam int SP_W        = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;

  localparam logic [PRIO_W-1:0] IDLE_RESET = 4'd9;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_CHECK  = 2'd1,
    CMD_FINISH = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_FULL    = 2'd1,
    ERR_NO_TASK = 2'd2
  } err_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_RD,
    S_POP_RD,
    S_TRY,
    S_DISP_RD
  } state_t;

endpackage

// ----- design/nptd_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nptd_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module nptd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/nested_priority_task_dispatcher_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nested_priority_task_dispatcher_core
// Priority task queue with FIFO order inside a level and a nesting stack.
// ----------------------------------------------------------------------------
// Usage:
//   An item (cmd, task_id, task_priority) is taken when start is high and
//   busy is low. Each item gives one result, shown for one cycle with done
//   high; the receiver cannot stall, so results are simply sampled.
//   States passed between the accepting edge and the done cycle:
//     add     none, S_ADD_RD when a slot freed by an earlier dispatch is reused
//     check   S_TRY, then S_DISP_RD when a task is dispatched
//     finish  S_POP_RD, S_TRY, then S_DISP_RD if dispatched; none with an empty stack
//   busy drops in the done cycle, so the next item may start there.
//   The extra states come from the registered read of the node memory (one
//   linked list per level, sentinel node at each tail) and of the stack.
//   idle_priority is written on the cfg channel; cfg_ready is high only
//   while the block is idle.
//   Reset (rst, synchronous) empties queue and stack and sets the running
//   level and idle_priority to 9. No memory clearing pass is needed.
// ----------------------------------------------------------------------------
module nested_priority_task_dispatcher_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    cmd,
  input  logic [nptd_pkg::ID_W-1:0]     task_id,
  input  logic [nptd_pkg::PRIO_W-1:0]   task_priority,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [nptd_pkg::PRIO_W-1:0]   cfg_data,
  output logic                          done,
  output logic                          dispatched,
  output logic [nptd_pkg::ID_W-1:0]     run_task_id,
  output logic [nptd_pkg::PRIO_W-1:0]   running_priority,
  output logic [nptd_pkg::OUT_CNT_W-1:0] pending_count,
  output logic [nptd_pkg::OUT_CNT_W-1:0] nest_level,
  output logic [1:0]                    error
);

  import nptd_pkg::*;

  state_t              state, state_next;
  logic [ID_W-1:0]     tid_r;
  logic [PRIO_W-1:0]   tpr_r, tpr_next;
  logic [QCNT_W-1:0]   count, count_next;
  logic [QCNT_W-1:0]   fresh, fresh_next;
  logic [PTR_W-1:0]    free_head, free_head_next;
  logic [PTR_W-1:0]    head [NUM_LEVELS];
  logic [PTR_W-1:0]    head_next [NUM_LEVELS];
  logic [PTR_W-1:0]    tail [NUM_LEVELS];
  logic [PTR_W-1:0]    tail_next [NUM_LEVELS];
  logic [SCNT_W-1:0]   saved_count, saved_count_next;
  logic [PRIO_W-1:0]   current_level, current_level_next;
  logic [PRIO_W-1:0]   idle_priority, idle_priority_next;
  logic [PRIO_W-1:0]   lvl_r, lvl_next;
  logic [PTR_W-1:0]    node_r, node_next;
  logic                result_done, result_done_next;
  logic                result_disp, result_disp_next;
  logic [ID_W-1:0]     result_id, result_id_next;
  err_t                result_err, result_err_next;

  // node memory: {id, next pointer}
  logic                q_we;
  logic [PTR_W-1:0]    q_waddr, q_raddr;
  logic [NODE_W-1:0]   q_wdata, q_rdata;
  // saved level stack
  logic                s_we;
  logic [SP_W-1:0]     s_waddr, s_raddr;
  logic [PRIO_W-1:0]   s_wdata, s_rdata;

  logic                any_ready;
  logic [PRIO_W-1:0]   best_lvl;
  logic [SCNT_W-1:0]   saved_dec;

  nptd_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_node_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  nptd_ram #(.WIDTH(PRIO_W), .DEPTH(NEST_DEPTH)) u_stack_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  // a level holds tasks when its head has not reached its sentinel tail
  always_comb begin
    any_ready = 1'b0;
    best_lvl  = '0;
    for (int p = NUM_LEVELS - 1; p >= 0; p--) begin
      if (head[p] != tail[p]) begin
        any_ready = 1'b1;
        best_lvl  = PRIO_W'(p);
      end
    end
  end

  assign saved_dec = saved_count - SCNT_W'(1);

  always_comb begin
    state_next         = state;
    tpr_next           = tpr_r;
    count_next         = count;
    fresh_next         = fresh;
    free_head_next     = free_head;
    head_next          = head;
    tail_next          = tail;
    saved_count_next   = saved_count;
    current_level_next = current_level;
    idle_priority_next = idle_priority;
    lvl_next           = lvl_r;
    node_next          = node_r;
    result_done_next   = 1'b0;
    result_disp_next   = 1'b0;
    result_id_next     = '0;
    result_err_next    = ERR_NONE;
    q_we               = 1'b0;
    q_waddr            = '0;
    q_wdata            = '0;
    q_raddr            = '0;
    s_we               = 1'b0;
    s_waddr            = '0;
    s_wdata            = '0;
    s_raddr            = '0;

    case (state)
      S_IDLE: begin
        if (cfg_valid) begin
          idle_priority_next = cfg_data;
          if (saved_count == '0) begin
            current_level_next = cfg_data;
          end
        end
        if (start) begin
          tpr_next = task_priority;
          case (cmd)
            CMD_ADD: begin
              if (count >= QCNT_W'(QUEUE_DEPTH)) begin
                result_done_next = 1'b1;
                result_err_next  = ERR_FULL;
              end else if (fresh < QCNT_W'(QUEUE_DEPTH)) begin
                // never-used node becomes the new sentinel
                q_we                     = 1'b1;
                q_waddr                  = tail[task_priority];
                q_wdata                  = {task_id, PTR_W'(fresh)};
                tail_next[task_priority] = PTR_W'(fresh);
                fresh_next               = fresh + QCNT_W'(1);
                count_next               = count + QCNT_W'(1);
                result_done_next         = 1'b1;
              end else begin
                q_raddr    = free_head;
                state_next = S_ADD_RD;
              end
            end
            CMD_CHECK: begin
              state_next = S_TRY;
            end
            CMD_FINISH: begin
              if (saved_count == '0) begin
                result_done_next = 1'b1;
                result_err_next  = ERR_NO_TASK;
              end else begin
                s_raddr          = saved_dec[SP_W-1:0];
                saved_count_next = saved_dec;
                state_next       = S_POP_RD;
              end
            end
            default: begin
              result_done_next = 1'b1;
            end
          endcase
        end
      end

      S_ADD_RD: begin
        // pop a recycled node from the free list
        free_head_next   = q_rdata[PTR_W-1:0];
        q_we             = 1'b1;
        q_waddr          = tail[tpr_r];
        q_wdata          = {tid_r, free_head};
        tail_next[tpr_r] = free_head;
        count_next       = count + QCNT_W'(1);
        result_done_next = 1'b1;
        state_next       = S_IDLE;
      end

      S_POP_RD: begin
        current_level_next = s_rdata;
        state_next         = S_TRY;
      end

      S_TRY: begin
        if (any_ready && (best_lvl < current_level) &&
            (saved_count < SCNT_W'(NEST_DEPTH))) begin
          q_raddr            = head[best_lvl];
          node_next          = head[best_lvl];
          lvl_next           = best_lvl;
          s_we               = 1'b1;
          s_waddr            = saved_count[SP_W-1:0];
          s_wdata            = current_level;
          saved_count_next   = saved_count + SCNT_W'(1);
          current_level_next = best_lvl;
          state_next         = S_DISP_RD;
        end else begin
          result_done_next = 1'b1;
          state_next       = S_IDLE;
        end
      end

      S_DISP_RD: begin
        head_next[lvl_r] = q_rdata[PTR_W-1:0];
        // old head node goes onto the free list
        q_we             = 1'b1;
        q_waddr          = node_r;
        q_wdata          = {{ID_W{1'b0}}, free_head};
        free_head_next   = node_r;
        count_next       = count - QCNT_W'(1);
        result_done_next = 1'b1;
        result_disp_next = 1'b1;
        result_id_next   = q_rdata[NODE_W-1:PTR_W];
        state_next       = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      fresh         <= '0;
      saved_count   <= '0;
      current_level <= IDLE_RESET;
      idle_priority <= IDLE_RESET;
      result_done   <= 1'b0;
      for (int p = 0; p < NUM_LEVELS; p++) begin
        head[p] <= PTR_W'(QUEUE_DEPTH + p);
        tail[p] <= PTR_W'(QUEUE_DEPTH + p);
      end
    end else begin
      state         <= state_next;
      count         <= count_next;
      fresh         <= fresh_next;
      saved_count   <= saved_count_next;
      current_level <= current_level_next;
      idle_priority <= idle_priority_next;
      result_done   <= result_done_next;
      head          <= head_next;
      tail          <= tail_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      tid_r <= task_id;
    end
    tpr_r       <= tpr_next;
    free_head   <= free_head_next;
    lvl_r       <= lvl_next;
    node_r      <= node_next;
    result_disp <= result_disp_next;
    result_id   <= result_id_next;
    result_err  <= result_err_next;
  end

  assign busy             = (state != S_IDLE);
  assign cfg_ready        = (state == S_IDLE);
  assign done             = result_done;
  assign dispatched       = result_disp;
  assign run_task_id      = result_id;
  assign error            = result_err;
  assign running_priority = current_level;
  assign pending_count    = OUT_CNT_W'(count);
  assign nest_level       = OUT_CNT_W'(saved_count);

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("pending count above queue depth");

  a_nest_bound: assert property (@(posedge clk) disable iff (rst)
    saved_count <= SCNT_W'(NEST_DEPTH))
    else $error("nesting stack overflow");

  a_disp_no_err: assert property (@(posedge clk) disable iff (rst)
    (done && dispatched) |-> (error == ERR_NONE && nest_level != '0))
    else $error("dispatch reported with error or empty stack");

  a_item_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted item neither in progress nor done");

  a_disp_level: assert property (@(posedge clk) disable iff (rst)
    (state == S_DISP_RD) |-> (current_level == lvl_r && any_ready))
    else $error("dispatch level mismatch");
`endif

endmodule

// ----- dv/nested_priority_task_dispatcher_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nested_priority_task_dispatcher_core testbench
// Drives add / check / finish items with random gaps and checks every result
// against a predictor of the sorted task queue and the nesting stack. The
// idle level is rewritten between phases, including the extremes.
// ----------------------------------------------------------------------------
module testbench;
  import nptd_pkg::*;

  typedef struct {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } task_entry_t;

  typedef struct {
    logic                 dispatched;
    logic [ID_W-1:0]      run_task_id;
    logic [PRIO_W-1:0]    running_priority;
    logic [OUT_CNT_W-1:0] pending_count;
    logic [OUT_CNT_W-1:0] nest_level;
    logic [1:0]           error;
  } dispatch_result_t;

  class dispatch_scoreboard;
    logic [PRIO_W-1:0] idle_level;
    logic [PRIO_W-1:0] level;
    task_entry_t       task_queue[$];
    logic [PRIO_W-1:0] level_stack[$];
    dispatch_result_t  expected_results[$];
    int errors;
    int n_dispatch;
    int n_full;
    int n_no_task;
    int deepest_nest;

    function new();
      idle_level = IDLE_RESET;
      level      = IDLE_RESET;
    endfunction

    function void set_idle(logic [PRIO_W-1:0] v);
      idle_level = v;
      if (level_stack.size() == 0) level = v;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // start the queue head if it is strictly more urgent than the running level and the stack has room
    function bit start_head(output logic [ID_W-1:0] id);
      task_entry_t head;
      id = '0;
      if (task_queue.size() == 0) return 0;
      head = task_queue[0];
      if (head.prio >= level) return 0;
      if (level_stack.size() >= NEST_DEPTH) return 0;
      void'(task_queue.pop_front());
      level_stack.push_back(level);
      level = head.prio;
      id = head.id;
      return 1;
    endfunction

    function void note_item(logic [1:0] c, logic [ID_W-1:0] id,
                            logic [PRIO_W-1:0] prio);
      dispatch_result_t r;
      task_entry_t      e;
      int               pos;
      logic [ID_W-1:0]  started;
      r = '{default: '0};
      started = '0;
      case (c)
        CMD_ADD: begin
          if (task_queue.size() >= QUEUE_DEPTH) begin
            r.error = ERR_FULL;
          end else begin
            pos = 0;
            while (pos < task_queue.size() && task_queue[pos].prio <= prio) pos++;
            e.id = id;
            e.prio = prio;
            task_queue.insert(pos, e);
          end
        end
        CMD_CHECK: begin
          r.dispatched = start_head(started);
        end
        CMD_FINISH: begin
          if (level_stack.size() == 0) begin
            r.error = ERR_NO_TASK;
          end else begin
            level = level_stack.pop_back();
            r.dispatched = start_head(started);
          end
        end
        default: ;  // unused code: state only
      endcase
      r.run_task_id      = r.dispatched ? started : '0;
      r.running_priority = level;
      r.pending_count    = OUT_CNT_W'(task_queue.size());
      r.nest_level       = OUT_CNT_W'(level_stack.size());
      if (r.dispatched) n_dispatch++;
      if (r.error == ERR_FULL) n_full++;
      if (r.error == ERR_NO_TASK) n_no_task++;
      if (level_stack.size() > deepest_nest) deepest_nest = level_stack.size();
      expected_results.push_back(r);
    endfunction

    function void compare_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(dispatch_result_t got);
      dispatch_result_t exp_r;
      if (expected_results.size() == 0) begin
        $error("result with no item outstanding");
        errors++;
        return;
      end
      exp_r = expected_results.pop_front();
      compare_field("dispatched", int'(exp_r.dispatched), int'(got.dispatched));
      compare_field("run_task_id", int'(exp_r.run_task_id), int'(got.run_task_id));
      compare_field("running_priority", int'(exp_r.running_priority),
                    int'(got.running_priority));
      compare_field("pending_count", int'(exp_r.pending_count),
                    int'(got.pending_count));
      compare_field("nest_level", int'(exp_r.nest_level), int'(got.nest_level));
      compare_field("error", int'(exp_r.error), int'(got.error));
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic [1:0]           cmd = CMD_ADD;
  logic [ID_W-1:0]      task_id = '0;
  logic [PRIO_W-1:0]    task_priority = '0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [PRIO_W-1:0]    cfg_data = '0;
  logic                 done;
  logic                 dispatched;
  logic [ID_W-1:0]      run_task_id;
  logic [PRIO_W-1:0]    running_priority;
  logic [OUT_CNT_W-1:0] pending_count;
  logic [OUT_CNT_W-1:0] nest_level;
  logic [1:0]           error;

  dispatch_scoreboard sb = new();
  bit quiet = 1'b0;
  int items_sent = 0;
  int idle_writes = 0;

  always #5 clk = ~clk;

  nested_priority_task_dispatcher_core u_top (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .cmd              (cmd),
    .task_id          (task_id),
    .task_priority    (task_priority),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .done             (done),
    .dispatched       (dispatched),
    .run_task_id      (run_task_id),
    .running_priority (running_priority),
    .pending_count    (pending_count),
    .nest_level       (nest_level),
    .error            (error)
  );

  always @(posedge clk) begin
    dispatch_result_t got;
    if (!rst && done) begin
      got.dispatched       = dispatched;
      got.run_task_id      = run_task_id;
      got.running_priority = running_priority;
      got.pending_count    = pending_count;
      got.nest_level       = nest_level;
      got.error            = error;
      sb.check_result(got);
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic issue_command(logic [1:0] c, logic [ID_W-1:0] id,
                               logic [PRIO_W-1:0] prio);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    cmd = c;
    task_id = id;
    task_priority = prio;
    start = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_item(c, id, prio);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_all_results();
    start = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_idle_priority(logic [PRIO_W-1:0] v);
    wait_all_results();
    cfg_data = v;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_idle(v);
    idle_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic random_command();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40)
      issue_command(CMD_ADD, ID_W'($urandom_range(0, 255)),
                    PRIO_W'($urandom_range(0, 15)));
    else if (r < 70)
      issue_command(CMD_CHECK, ID_W'($urandom_range(0, 255)),
                    PRIO_W'($urandom_range(0, 15)));
    else if (r < 95)
      issue_command(CMD_FINISH, ID_W'($urandom_range(0, 255)),
                    PRIO_W'($urandom_range(0, 15)));
    else
      issue_command(2'd3, ID_W'($urandom_range(0, 255)),
                    PRIO_W'($urandom_range(0, 15)));
  endtask

  // each step queues a task up to three levels below the running level, then checks
  task automatic nest_ladder();
    int n;
    int lvl;
    int p;
    n = $urandom_range(2, 8);
    for (int k = 0; k < n; k++) begin
      lvl = int'(sb.level);
      if (lvl == 0) break;
      p = lvl - 1 - $urandom_range(0, (lvl > 2) ? 2 : lvl - 1);
      issue_command(CMD_ADD, ID_W'($urandom_range(0, 255)), PRIO_W'(p));
      issue_command(CMD_CHECK, ID_W'($urandom_range(0, 255)),
                    PRIO_W'($urandom_range(0, 15)));
    end
  endtask

  task automatic run_phase(int n_items, bit pause_midway);
    int stop_at;
    int half;
    int r;
    stop_at = items_sent + n_items;
    half = items_sent + n_items / 2;
    while (items_sent < stop_at) begin
      if (pause_midway && items_sent >= half) begin
        wait_all_results();
        pause_midway = 1'b0;
      end
      r = $urandom_range(0, 99);
      if (r < 45) begin
        random_command();
      end else if (r < 70) begin
        nest_ladder();
      end else if (r < 85) begin
        repeat ($urandom_range(1, 6))
          issue_command(CMD_FINISH, ID_W'($urandom_range(0, 255)),
                        PRIO_W'($urandom_range(0, 15)));
      end else begin
        repeat ($urandom_range(2, 10))
          issue_command(CMD_ADD, ID_W'($urandom_range(0, 255)),
                        PRIO_W'($urandom_range(0, 15)));
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty-state cases, extremes, equal-priority order, overflow
    issue_command(CMD_FINISH, 8'hff, 4'hf);
    issue_command(2'd3, 8'h00, 4'h0);
    issue_command(CMD_CHECK, 8'haa, 4'h5);
    issue_command(CMD_ADD, 8'hff, 4'hf);
    issue_command(CMD_ADD, 8'h00, 4'h0);
    issue_command(CMD_ADD, 8'h11, 4'h5);
    issue_command(CMD_ADD, 8'h12, 4'h5);
    issue_command(CMD_CHECK, 8'h00, 4'h0);
    issue_command(CMD_CHECK, 8'h55, 4'ha);
    issue_command(CMD_FINISH, 8'h00, 4'h0);
    issue_command(CMD_FINISH, 8'h00, 4'h0);
    issue_command(CMD_FINISH, 8'h00, 4'h0);
    for (int i = 0; i < 16; i++)
      issue_command(CMD_ADD, (i % 2) ? 8'h55 : 8'haa, PRIO_W'(i));

    write_idle_priority(4'd15);
    run_phase(130, 1'b1);
    write_idle_priority(4'd0);
    run_phase(110, 1'b0);
    write_idle_priority(PRIO_W'($urandom_range(1, 14)));
    run_phase(120, 1'b0);
    write_idle_priority(4'd9);
    run_phase(120, 1'b0);
    quiet = 1'b1;
    write_idle_priority(PRIO_W'($urandom_range(0, 15)));
    run_phase(100, 1'b0);

    wait_all_results();
    repeat (8) @(posedge clk);
    $display("Ran %0d items and %0d idle_priority writes: %0d dispatches,",
             items_sent, idle_writes, sb.n_dispatch);
    $display("%0d full-queue drops, %0d finishes with nothing running, nesting up to %0d.",
             sb.n_full, sb.n_no_task, sb.deepest_nest);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** nested_priority_task_dispatcher_core: PASSED **");
    end else begin
      $display("** nested_priority_task_dispatcher_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("timeout waiting for the block");
    $display("** nested_priority_task_dispatcher_core: FAILED **");
    $finish;
  end

endmodule
